// ===== rtl/ssv_pkg.sv =====
// Shared types, constants and a helper function of the square-wave step sequencer voice.
package ssv_pkg;

    // Default geometry of the note grid.
    localparam int DEF_ROWS  = 6;
    localparam int DEF_STEPS = 16;

    // Field widths.
    localparam int FREQ_W     = 15;
    localparam int SPS_W      = 16;
    localparam int ACC_W      = 16;
    localparam int POS_W      = 12;
    localparam int BTN_W      = 8;
    localparam int SAMPLE_W   = 15;
    localparam int STEP_OUT_W = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int ENV_W      = 14;

    // Audio constants.
    localparam int RATE_HZ    = 44100;
    localparam int HALF_RATE  = 22050;
    localparam int DECAY_LEN  = 12000;
    // A gain of 1500 over a decay length of 12000 is exactly a divide by 8.
    localparam int GAIN_SHIFT = 3;
    localparam int GAIN       = 1500;

    // Pointer hit test: grid origin and cell pitch in pixels.
    localparam int ORIGIN_PX   = 20;
    localparam int PITCH_PX    = 25;
    // Division by the pitch is a multiply by a rounded-up reciprocal.
    localparam int RECIP_SHIFT = 16;
    localparam int RECIP_MUL   = ((1 << RECIP_SHIFT) + PITCH_PX - 1) / PITCH_PX;
    localparam int RECIP_W     = 12;
    localparam int DIFF_W      = POS_W - 1;
    localparam int PROD_W      = DIFF_W + RECIP_W;
    localparam int QUOT_W      = PROD_W - RECIP_SHIFT;

    // Register map.
    localparam int                   NUM_FREQ_REGS = 6;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_LEN  = CFG_IDX_W'(6);
    localparam logic [SPS_W-1:0]     SPS_RESET     = SPS_W'(5512);

    // Input word kinds.
    typedef enum logic {
        MODE_TICK  = 1'b0,
        MODE_CLICK = 1'b1
    } mode_t;

    // Per-cycle control of each row cell; tick and wrap are the same for every row.
    typedef struct packed {
        logic tick;    // a sample tick was accepted
        logic wrap;    // this tick ends the current step
        logic toggle;  // toggle the selected column in this row
        logic cfg_wr;  // load this row's frequency register
    } cell_ctrl_t;

    function automatic logic [FREQ_W-1:0] freq_reset(input int row);
        logic [FREQ_W-1:0] f;
        case (row)
            0:       f = FREQ_W'(330);
            1:       f = FREQ_W'(294);
            2:       f = FREQ_W'(261);
            3:       f = FREQ_W'(220);
            4:       f = FREQ_W'(196);
            default: f = FREQ_W'(147);
        endcase
        return f;
    endfunction

endpackage

// ===== rtl/ssv_row_cell.sv =====
// One row cell: note mask, frequency register and phase accumulator, adding its square wave.
module ssv_row_cell
    import ssv_pkg::*;
#(
    parameter int ROWS    = DEF_ROWS,
    parameter int STEPS   = DEF_STEPS,
    parameter int ROW_IDX = 0
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  cell_ctrl_t                          ctrl,
    input  logic [$clog2(STEPS)-1:0]            play_step,
    input  logic [$clog2(STEPS)-1:0]            col_idx,
    input  logic [FREQ_W-1:0]                   freq_data,
    input  logic signed [$clog2(ROWS+1):0]      sum_in,
    output logic signed [$clog2(ROWS+1):0]      sum_out
);

    localparam int SUM_W = $clog2(ROWS + 1) + 1;

    logic [STEPS-1:0]        mask_reg, mask_next;
    logic [ACC_W-1:0]        acc_reg, acc_next;
    logic [FREQ_W-1:0]       freq_reg, freq_next;
    logic [ACC_W:0]          phase_sum;
    logic [ACC_W-1:0]        acc_adv;
    logic                    active;
    logic                    high_half;
    logic signed [SUM_W-1:0] delta;

    // The accumulator stays below the rate and the frequency is below 32768,
    // so one conditional subtract keeps it reduced.
    always_comb
    begin
        phase_sum = {1'b0, acc_reg} + (ACC_W + 1)'(freq_reg);
        if (phase_sum >= (ACC_W + 1)'(RATE_HZ))
        begin
            acc_adv = ACC_W'(phase_sum - (ACC_W + 1)'(RATE_HZ));
        end
        else
        begin
            acc_adv = ACC_W'(phase_sum);
        end
    end

    always_comb
    begin
        acc_next = acc_reg;
        if (ctrl.tick)
        begin
            acc_next = ctrl.wrap ? '0 : acc_adv;
        end
        mask_next = ctrl.toggle ? (mask_reg ^ (STEPS'(1) << col_idx)) : mask_reg;
        freq_next = ctrl.cfg_wr ? freq_data : freq_reg;
    end

    always_comb
    begin
        active    = mask_reg[play_step];
        high_half = (acc_reg < ACC_W'(HALF_RATE));
        if (!active)
        begin
            delta = '0;
        end
        else if (high_half)
        begin
            delta = SUM_W'(1);
        end
        else
        begin
            delta = '1;
        end
        sum_out = sum_in + delta;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= '0;
            acc_reg  <= '0;
            freq_reg <= freq_reset(ROW_IDX);
        end
        else
        begin
            mask_reg <= mask_next;
            acc_reg  <= acc_next;
            freq_reg <= freq_next;
        end
    end

endmodule

// ===== rtl/ssv_shaper.sv =====
// Envelope and gain stage: captures the row sum, scales it by the decay envelope, holds the word.
module ssv_shaper
    import ssv_pkg::*;
#(
    parameter int ROWS  = DEF_ROWS,
    parameter int STEPS = DEF_STEPS
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                load,
    input  logic signed [$clog2(ROWS+1):0]      sum,
    input  logic [SPS_W-1:0]                    sample_cnt,
    input  logic [$clog2(STEPS)-1:0]            play_step,
    output logic                                accept_ok,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [SAMPLE_W-1:0]          sample,
    output logic [STEP_OUT_W-1:0]               current_step
);

    localparam int SUM_W  = $clog2(ROWS + 1) + 1;
    localparam int MAG_W  = SUM_W - 1;
    localparam int PROD_M = MAG_W + ENV_W;
    localparam int SW     = $clog2(STEPS);

    logic                    s1_valid_reg, s1_valid_next;
    logic signed [SUM_W-1:0] s1_sum_reg;
    logic [ENV_W-1:0]        s1_env_reg;
    logic [SW-1:0]           s1_step_reg;
    logic                    out_valid_reg, out_valid_next;
    logic [SAMPLE_W-1:0]     sample_reg, sample_next;
    logic [STEP_OUT_W-1:0]   step_out_reg;
    logic [ENV_W-1:0]        env;
    logic [SUM_W-1:0]        abs_sum;
    logic [PROD_M-1:0]       prod;
    logic [SAMPLE_W-1:0]     mag;
    logic                    out_free;
    logic                    s1_adv;

    always_comb
    begin
        if (sample_cnt < SPS_W'(DECAY_LEN))
        begin
            env = ENV_W'(SPS_W'(DECAY_LEN) - sample_cnt);
        end
        else
        begin
            env = '0;
        end
    end

    always_comb
    begin
        out_free       = !out_valid_reg || out_ready;
        s1_adv         = s1_valid_reg && out_free;
        accept_ok      = !s1_valid_reg || out_free;
        s1_valid_next  = load ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_reg);
        out_valid_next = s1_adv ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    end

    always_comb
    begin
        abs_sum     = s1_sum_reg[SUM_W-1] ? SUM_W'(-s1_sum_reg) : SUM_W'(s1_sum_reg);
        prod        = PROD_M'(abs_sum[MAG_W-1:0]) * PROD_M'(s1_env_reg);
        mag         = SAMPLE_W'(prod >> GAIN_SHIFT);
        sample_next = s1_sum_reg[SUM_W-1] ? (~mag + SAMPLE_W'(1)) : mag;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            s1_sum_reg  <= sum;
            s1_env_reg  <= env;
            s1_step_reg <= play_step;
        end
        if (s1_adv)
        begin
            sample_reg   <= sample_next;
            step_out_reg <= STEP_OUT_W'(s1_step_reg);
        end
    end

    assign out_valid    = out_valid_reg;
    assign sample       = sample_reg;
    assign current_step = step_out_reg;

endmodule

// ===== rtl/step_sequencer_square_voice.sv =====
// Top level of the square-wave step sequencer voice.
// This voice plays a grid of ROWS note rows by STEPS steps, cleared at reset. An input word with
// mode high is a pointer click: with button 0 and a position on the grid (origin 20 pixels, pitch
// 25 pixels, padding counts toward the cell above and to the left) it toggles one note, and it
// returns nothing. A word with mode low is a sample tick: it returns one word holding the sample
// and the step that was playing. The block takes one input word per clock cycle when the output
// side keeps up. Accepting a tick captures the row sum and the envelope in the capture stage,
// and the scaled sample then moves into the output register as soon as that register is free.
// While the output is held off, one more tick can wait in the capture stage; after that in_ready
// stays low, for clicks as well, until the output word is taken. The configuration port is
// always ready and is meant to be written while the voice is idle.
module step_sequencer_square_voice
    import ssv_pkg::*;
#(
    parameter int ROWS  = DEF_ROWS,
    parameter int STEPS = DEF_STEPS
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        mode,
    input  logic [BTN_W-1:0]            button,
    input  logic signed [POS_W-1:0]     pos_x,
    input  logic signed [POS_W-1:0]     pos_y,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic signed [SAMPLE_W-1:0]  sample,
    output logic [STEP_OUT_W-1:0]       current_step,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]       cfg_data
);

    localparam int SW    = $clog2(STEPS);
    localparam int SUM_W = $clog2(ROWS + 1) + 1;

    // Sequencer position.
    logic [SW-1:0]           step_reg, step_next;
    logic [SPS_W-1:0]        sample_cnt_reg, sample_cnt_next;
    logic [SPS_W-1:0]        sps_reg, sps_next;

    logic                    accept_ok;
    logic                    in_accept;
    logic                    tick_acc;
    logic                    click_acc;
    logic [SPS_W:0]          idx_inc;
    logic                    wrap;

    // Pointer hit test.
    logic signed [POS_W:0]   dx_full, dy_full;
    logic [PROD_W-1:0]       col_prod, row_prod;
    logic [QUOT_W-1:0]       col_q, row_q;
    logic                    hit;

    // Row sum chain: each cell adds its square wave to the partial sum of the cells above it.
    logic signed [SUM_W-1:0] chain_sum [0:ROWS];

    assign in_ready  = accept_ok;
    assign cfg_ready = 1'b1;
    assign in_accept = in_valid && in_ready;
    assign tick_acc  = in_accept && (mode_t'(mode) == MODE_TICK);
    assign click_acc = in_accept && (mode_t'(mode) == MODE_CLICK);

    // The step ends once the incremented sample count reaches the step length register, or when
    // the 16-bit count would roll over. A zero setting ends the step after every sample.
    always_comb
    begin
        idx_inc = {1'b0, sample_cnt_reg} + (SPS_W + 1)'(1);
        wrap    = (idx_inc >= {1'b0, sps_reg});
    end

    always_comb
    begin
        step_next       = step_reg;
        sample_cnt_next = sample_cnt_reg;
        if (tick_acc)
        begin
            if (wrap)
            begin
                sample_cnt_next = '0;
                step_next       = (step_reg == SW'(STEPS - 1)) ? '0 : step_reg + SW'(1);
            end
            else
            begin
                sample_cnt_next = idx_inc[SPS_W-1:0];
            end
        end
        sps_next = sps_reg;
        if (cfg_valid && (cfg_index == REG_STEP_LEN))
        begin
            sps_next = cfg_data[SPS_W-1:0];
        end
    end

    // Positions are offset from the grid origin; anything left of or above it is rejected.
    // On the grid the offset is below 2048, so the pitch divide is a small reciprocal multiply.
    always_comb
    begin
        dx_full  = {pos_x[POS_W-1], pos_x} - (POS_W + 1)'(ORIGIN_PX);
        dy_full  = {pos_y[POS_W-1], pos_y} - (POS_W + 1)'(ORIGIN_PX);
        col_prod = PROD_W'(dx_full[DIFF_W-1:0]) * PROD_W'(RECIP_MUL);
        row_prod = PROD_W'(dy_full[DIFF_W-1:0]) * PROD_W'(RECIP_MUL);
        col_q    = col_prod[RECIP_SHIFT +: QUOT_W];
        row_q    = row_prod[RECIP_SHIFT +: QUOT_W];
        hit      = click_acc && (button == '0)
                   && !dx_full[POS_W] && !dy_full[POS_W]
                   && (col_q < QUOT_W'(STEPS)) && (row_q < QUOT_W'(ROWS));
    end

    assign chain_sum[0] = '0;

    for (genvar j = 0; j < ROWS; j++)
    begin : g_row
        cell_ctrl_t ctrl;

        always_comb
        begin
            ctrl.tick   = tick_acc;
            ctrl.wrap   = wrap;
            ctrl.toggle = hit && (row_q == QUOT_W'(j));
            ctrl.cfg_wr = cfg_valid && (j < NUM_FREQ_REGS) && (cfg_index == CFG_IDX_W'(j));
        end

        ssv_row_cell #(
            .ROWS    (ROWS),
            .STEPS   (STEPS),
            .ROW_IDX (j)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .play_step (step_reg),
            .col_idx   (col_q[SW-1:0]),
            .freq_data (cfg_data[FREQ_W-1:0]),
            .sum_in    (chain_sum[j]),
            .sum_out   (chain_sum[j+1])
        );
    end

    // The shaper captures the row sum and the envelope of the pre-tick sample count at acceptance, so the
    // sequencer state can move on to the next word in the same cycle.
    ssv_shaper #(
        .ROWS  (ROWS),
        .STEPS (STEPS)
    ) u_shaper (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (tick_acc),
        .sum          (chain_sum[ROWS]),
        .sample_cnt   (sample_cnt_reg),
        .play_step    (step_reg),
        .accept_ok    (accept_ok),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .sample       (sample),
        .current_step (current_step)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg       <= '0;
            sample_cnt_reg <= '0;
            sps_reg        <= SPS_RESET;
        end
        else
        begin
            step_reg       <= step_next;
            sample_cnt_reg <= sample_cnt_next;
            sps_reg        <= sps_next;
        end
    end

endmodule

// ===== rtl/ssv_checker.sv =====
// Port-level assertions for the square-wave step sequencer voice, bound to the top level.
module ssv_checker
    import ssv_pkg::*;
#(
    parameter int ROWS = DEF_ROWS
)
(
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic                        mode,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic signed [SAMPLE_W-1:0]  sample,
    input logic [STEP_OUT_W-1:0]       current_step
);

    localparam int MAX_MAG = GAIN * ROWS;

    logic [2:0] pending_reg, pending_next;
    logic       tick_acc;
    logic       out_acc;

    assign tick_acc = in_valid && in_ready && (mode_t'(mode) == MODE_TICK);
    assign out_acc  = out_valid && out_ready;

    // Ticks accepted whose sample word has not yet been taken.
    always_comb
    begin
        pending_next = pending_reg + 3'(tick_acc) - 3'(out_acc);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    a_reset_quiet: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("output word valid during reset");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(sample) && $stable(current_step))
        else $error("stalled output word changed");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pending_reg != 3'd0)
        else $error("output word without an accepted tick");

    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= 3'd2)
        else $error("more ticks in flight than pipeline stages");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (sample <= MAX_MAG) && (sample >= -MAX_MAG))
        else $error("sample beyond full-scale magnitude");

endmodule

bind step_sequencer_square_voice ssv_checker #(.ROWS(ROWS)) u_ssv_checker (.*);
